/* src/sfr_pkg.sv */
`default_nettype none

package sfr_pkg;

    // Window and replacement sizes
    localparam int PATTERN_MAX = 8;
    localparam int REPLACE_MAX = 16;

    localparam int CNT_W  = $clog2(PATTERN_MAX + 1);
    localparam int RIDX_W = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;
    localparam int RLEN_W = $clog2(REPLACE_MAX + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES  = 3'd0,
        CFG_PATTERN_LENGTH = 3'd1,
        CFG_REPLACE_LOW    = 3'd2,
        CFG_REPLACE_HIGH   = 3'd3,
        CFG_REPLACE_LENGTH = 3'd4
    } cfg_index_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_REPL,
        ST_FLUSH
    } sfr_state_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       text_end;
    } out_word_t;

    // Per-cycle commands from the sequencer to the cell chain
    typedef struct packed {
        logic [PATTERN_MAX-1:0] load;
        logic                   shift;
    } cell_ctl_t;

    // Clamp a written pattern length to 1..PATTERN_MAX
    function automatic logic [CNT_W-1:0] eff_plen(input logic [3:0] raw);
        logic [CNT_W-1:0] n;
        begin
            if (raw == 4'd0)
                n = CNT_W'(1);
            else if (int'(raw) > PATTERN_MAX)
                n = CNT_W'(PATTERN_MAX);
            else
                n = CNT_W'(raw);
            return n;
        end
    endfunction

    // Clamp a written replacement length to 0..REPLACE_MAX
    function automatic logic [RLEN_W-1:0] eff_rlen(input logic [4:0] raw);
        logic [RLEN_W-1:0] n;
        begin
            if (int'(raw) > REPLACE_MAX)
                n = RLEN_W'(REPLACE_MAX);
            else
                n = RLEN_W'(raw);
            return n;
        end
    endfunction

endpackage

`default_nettype wire

/* src/sfr_cell.sv */
`default_nettype none

module sfr_cell (
    input  wire logic       clk,
    input  wire logic       load,
    input  wire logic       shift,
    input  wire logic [7:0] in_byte,
    input  wire logic [7:0] next_byte,
    input  wire logic [7:0] pat_byte,
    input  wire logic       used,
    output logic [7:0]      byte_q,
    output logic            match
);

    logic [7:0] byte_reg;

    // Take a new text byte, or the neighbor's byte when the window advances
    always_ff @(posedge clk)
    begin
        if (load)
            byte_reg <= in_byte;
        else if (shift)
            byte_reg <= next_byte;
    end

    assign byte_q = byte_reg;

    // Cells beyond the pattern length never block a match
    assign match = !used || (byte_reg == pat_byte);

endmodule

`default_nettype wire

/* src/sfr_ctrl.sv */
`default_nettype none

module sfr_ctrl (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             in_final,
    input  wire logic                             cfg_clear,
    input  wire logic [sfr_pkg::CNT_W-1:0]        plen,
    input  wire logic [sfr_pkg::RLEN_W-1:0]       rlen,
    input  wire logic [sfr_pkg::REPLACE_MAX*8-1:0] replace,
    input  wire logic [7:0]                       head_byte,
    input  wire logic                             hit,
    output sfr_pkg::cell_ctl_t                    cell_ctl,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output sfr_pkg::out_word_t                    out_data
);

    import sfr_pkg::*;

    sfr_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [RIDX_W-1:0] ridx_reg, ridx_next;
    logic              fin_reg;
    logic              out_valid_reg;
    out_word_t         out_data_reg;

    logic              slot_free;
    logic              emit;
    out_word_t         emit_word;
    logic              repl_last;
    logic              head_last;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign repl_last = ({1'b0, ridx_reg} == RLEN_W'(rlen - RLEN_W'(1)));
    assign head_last = (count_reg == CNT_W'(1));

    // State, window fill and replacement index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ridx_reg  <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ridx_reg  <= ridx_next;
            if (state_reg == ST_IDLE && in_valid)
                fin_reg <= in_final;
        end
    end

    // Sequence append, compare, replace and flush
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ridx_next  = ridx_reg;
        emit       = 1'b0;
        emit_word  = '0;
        cell_ctl   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    for (int i = 0; i < PATTERN_MAX; i++)
                        cell_ctl.load[i] = (count_reg == CNT_W'(i));
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                if (count_reg == plen)
                begin
                    if (hit)
                    begin
                        count_next = '0;
                        ridx_next  = '0;
                        state_next = (rlen != '0) ? ST_REPL : ST_IDLE;
                    end
                    else if (slot_free)
                    begin
                        emit               = 1'b1;
                        emit_word.out_byte = head_byte;
                        emit_word.run_end  = !fin_reg || head_last;
                        emit_word.text_end = fin_reg && head_last;
                        cell_ctl.shift     = 1'b1;
                        count_next         = count_reg - CNT_W'(1);
                        state_next         = (fin_reg && !head_last) ? ST_FLUSH : ST_IDLE;
                    end
                end
                else
                begin
                    state_next = fin_reg ? ST_FLUSH : ST_IDLE;
                end
            end

            ST_REPL:
            begin
                if (slot_free)
                begin
                    emit               = 1'b1;
                    emit_word.out_byte = replace[{ridx_reg, 3'b000} +: 8];
                    emit_word.run_end  = repl_last;
                    emit_word.text_end = repl_last && fin_reg;
                    ridx_next          = ridx_reg + RIDX_W'(1);
                    if (repl_last)
                        state_next = ST_IDLE;
                end
            end

            ST_FLUSH:
            begin
                if (slot_free)
                begin
                    emit               = 1'b1;
                    emit_word.out_byte = head_byte;
                    emit_word.run_end  = head_last;
                    emit_word.text_end = head_last;
                    cell_ctl.shift     = 1'b1;
                    count_next         = count_reg - CNT_W'(1);
                    if (head_last)
                        state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Drop the window when the pattern length changes
        if (cfg_clear)
            count_next = '0;
    end

    // Hold one result word until the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_data_reg <= emit_word;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

/* src/stream_find_replace_unit.sv */
// Streaming find and replace over a byte stream. Bytes enter a window held
// in a chain of cells, one byte per cell; once the window holds
// pattern_length bytes it is compared with the pattern in all cells at once. A match
// emits the replacement bytes (none if replace_length is zero) and empties
// the window; a miss emits the oldest byte and advances the chain. A byte
// marked final also pushes out whatever stays in the window. Each result word
// carries run_end on the last word caused by an input byte and text_end on
// the last word of the text. A byte that emits at most one word is first
// accepted, then compared and emitted; a match then emits the replacement
// bytes and a final byte then emits each byte left in the window, since
// the sequencer loads the single output register with one word per cycle
// while the output does not stall. Configure only while idle;
// writing pattern_length discards the window.
`default_nettype none

module stream_find_replace_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire sfr_pkg::in_word_t                 in_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output sfr_pkg::out_word_t                     out_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import sfr_pkg::*;

    logic [PATTERN_MAX*8-1:0] pattern_reg;
    logic [CNT_W-1:0]         plen_reg;
    logic [63:0]              repl_lo_reg;
    logic [63:0]              repl_hi_reg;
    logic [RLEN_W-1:0]        rlen_reg;

    logic                     cfg_clear;
    logic [2*64-1:0]          repl_all;
    cell_ctl_t                cell_ctl;
    logic [7:0]               cell_byte [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]   cell_match;
    logic                     hit;

    assign cfg_ready = 1'b1;
    assign cfg_clear = cfg_valid && (cfg_index == CFG_PATTERN_LENGTH);

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            plen_reg    <= CNT_W'(1);
            repl_lo_reg <= '0;
            repl_hi_reg <= '0;
            rlen_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PATTERN_BYTES:  pattern_reg <= cfg_data[PATTERN_MAX*8-1:0];
                CFG_PATTERN_LENGTH: plen_reg    <= eff_plen(cfg_data[3:0]);
                CFG_REPLACE_LOW:    repl_lo_reg <= cfg_data;
                CFG_REPLACE_HIGH:   repl_hi_reg <= cfg_data;
                CFG_REPLACE_LENGTH: rlen_reg    <= eff_rlen(cfg_data[4:0]);
                default:            ;
            endcase
        end
    end

    assign repl_all = {repl_hi_reg, repl_lo_reg};

    // Build the window chain; each cell takes from its right neighbor
    for (genvar i = 0; i < PATTERN_MAX; i++)
    begin : g_cell
        logic [7:0] next_byte;

        if (i == PATTERN_MAX - 1)
        begin : g_tail
            assign next_byte = '0;
        end
        else
        begin : g_link
            assign next_byte = cell_byte[i+1];
        end

        sfr_cell u_cell (
            .clk       (clk),
            .load      (cell_ctl.load[i]),
            .shift     (cell_ctl.shift),
            .in_byte   (in_data.in_byte),
            .next_byte (next_byte),
            .pat_byte  (pattern_reg[i*8 +: 8]),
            .used      (CNT_W'(i) < plen_reg),
            .byte_q    (cell_byte[i]),
            .match     (cell_match[i])
        );
    end

    assign hit = &cell_match;

    sfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_final  (in_data.final_byte),
        .cfg_clear (cfg_clear),
        .plen      (plen_reg),
        .rlen      (rlen_reg),
        .replace   (repl_all[REPLACE_MAX*8-1:0]),
        .head_byte (cell_byte[0]),
        .hit       (hit),
        .cell_ctl  (cell_ctl),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

/* src/sfr_checker.sv */
`default_nettype none

module sfr_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_stall,
    input  wire sfr_pkg::in_word_t              in_data,
    input  wire logic                           out_valid,
    input  wire logic                           out_stall,
    input  wire sfr_pkg::out_word_t             out_data,
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data
);

    import sfr_pkg::*;

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result word changed or dropped");

    // Mark end of text only on the last word of a run
    a_text_end_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.text_end |-> out_data.run_end)
        else $error("text_end without run_end");

    // Compare the window before taking another byte
    a_eval_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted in back-to-back cycles");

    // Keep the configuration port always open
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind stream_find_replace_unit sfr_checker u_sfr_checker (.*);

`default_nettype wire

/* tb/sv/text_rewrite_check.sv */
`timescale 1ns / 100ps

module text_rewrite_check (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  sfr_pkg::in_word_t              in_data,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  sfr_pkg::out_word_t             out_data,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             words_due
);

    import sfr_pkg::*;

    // Shadow copy of the rule registers
    logic [63:0] find_bytes;
    logic [3:0]  find_len_raw;
    logic [63:0] subst_lo;
    logic [63:0] subst_hi;
    logic [4:0]  subst_len_raw;

    // Shadow of the match window, oldest byte at index 0
    logic [7:0]  held [PATTERN_MAX];
    int          held_count;

    // Rewritten words still owed by the block, oldest first
    out_word_t   rewritten_due [$];
    out_word_t   head;

    // Clamp the pattern length to 1..PATTERN_MAX
    function automatic int find_width();
        int n;
        begin
            n = int'(find_len_raw);
            if (n == 0)
                n = 1;
            if (n > PATTERN_MAX)
                n = PATTERN_MAX;
            return n;
        end
    endfunction

    // Clamp the replacement length to 0..REPLACE_MAX
    function automatic int subst_width();
        int n;
        begin
            n = int'(subst_len_raw);
            if (n > REPLACE_MAX)
                n = REPLACE_MAX;
            return n;
        end
    endfunction

    function automatic logic [7:0] subst_byte(input int k);
        begin
            if (k < 8)
                return subst_lo[k*8 +: 8];
            return subst_hi[(k-8)*8 +: 8];
        end
    endfunction

    // Push one text byte through the window and queue the words it causes
    task automatic rewrite_byte(input in_word_t w);
        int        width;
        int        rlen;
        bit        hit;
        out_word_t ow;
        logic [7:0] produced [$];
        begin
            width = find_width();
            if (held_count >= width)
                held_count = 0;
            held[held_count] = w.in_byte;
            held_count++;

            // Compare a full window; replace on a hit, else release the oldest byte
            if (held_count == width)
            begin
                hit = 1'b1;
                for (int i = 0; i < width; i++)
                begin
                    if (held[i] != find_bytes[i*8 +: 8])
                        hit = 1'b0;
                end
                if (hit)
                begin
                    rlen = subst_width();
                    for (int k = 0; k < rlen; k++)
                        produced.push_back(subst_byte(k));
                    held_count = 0;
                end
                else
                begin
                    produced.push_back(held[0]);
                    for (int i = 0; i + 1 < held_count; i++)
                        held[i] = held[i+1];
                    held_count--;
                end
            end

            // Flush what is left literally at the end of the text
            if (w.final_byte)
            begin
                for (int i = 0; i < held_count; i++)
                    produced.push_back(held[i]);
                held_count = 0;
            end

            // Mark the last word of this byte, and of the text
            for (int i = 0; i < produced.size(); i++)
            begin
                ow.out_byte = produced[i];
                ow.run_end  = (i == produced.size() - 1);
                ow.text_end = (i == produced.size() - 1) && w.final_byte;
                rewritten_due.push_back(ow);
            end
        end
    endtask

    task automatic store_rule(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
        begin
            case (idx)
                CFG_PATTERN_BYTES:
                    find_bytes = val;
                CFG_PATTERN_LENGTH:
                begin
                    find_len_raw = val[3:0];
                    held_count   = 0;
                end
                CFG_REPLACE_LOW:
                    subst_lo = val;
                CFG_REPLACE_HIGH:
                    subst_hi = val;
                CFG_REPLACE_LENGTH:
                    subst_len_raw = val[4:0];
                default:
                    ;
            endcase
        end
    endtask

    task automatic count_mismatch();
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: word mismatch: expected byte %02h run_end %0b text_end %0b,",
                         $realtime, head.out_byte, head.run_end, head.text_end);
                $display("    got byte %02h run_end %0b text_end %0b",
                         out_data.out_byte, out_data.run_end, out_data.text_end);
            end
        end
    endtask

    // Apply writes, check returned words, predict from accepted bytes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            find_bytes    = '0;
            find_len_raw  = 4'd1;
            subst_lo      = '0;
            subst_hi      = '0;
            subst_len_raw = '0;
            held_count    = 0;
            rewritten_due.delete();
            mismatches    = 0;
            words_due     = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                store_rule(cfg_index, cfg_data);

            if (out_valid && !out_stall)
            begin
                if (rewritten_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected word: byte %02h run_end %0b text_end %0b",
                                 $realtime, out_data.out_byte, out_data.run_end,
                                 out_data.text_end);
                end
                else
                begin
                    head = rewritten_due.pop_front();
                    if (out_data.out_byte !== head.out_byte
                        || out_data.run_end !== head.run_end
                        || out_data.text_end !== head.text_end)
                        count_mismatch();
                end
            end

            if (in_valid && !in_stall)
                rewrite_byte(in_data);

            words_due = rewritten_due.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import sfr_pkg::*;

    localparam int HANG_LIMIT   = 4000;
    localparam int SETTLE       = 40;
    localparam int RANDOM_BYTES = 350;

    // Receiver stall patterns
    localparam int STALL_NONE     = 0;
    localparam int STALL_LIGHT    = 1;
    localparam int STALL_HEAVY    = 2;
    localparam int STALL_PERIODIC = 3;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_word_t              in_data;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_word_t             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int   mismatches;
    int   words_due;

    logic in_took;
    logic cfg_took;
    int   quiet_cycles = 0;
    int   stall_mode   = STALL_NONE;
    int   stall_phase  = 0;
    int   burst_left;
    int   gap_max;
    int   bytes_sent;

    stream_find_replace_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    text_rewrite_check scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .words_due  (words_due)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    // Stall the output on a pattern that is picked anew at random
    always @(negedge clk)
    begin
        if (stall_phase == 0)
        begin
            stall_mode  <= $urandom_range(STALL_NONE, STALL_PERIODIC);
            stall_phase <= $urandom_range(16, 96);
        end
        else
            stall_phase <= stall_phase - 1;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= ((stall_phase % 8) < 3);
        endcase
    end

    // Note handshakes for the stimulus, which runs on the falling edge
    always @(posedge clk)
    begin
        in_took  <= in_valid && !in_stall;
        cfg_took <= cfg_valid && cfg_ready;
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic cfg_write(input cfg_index_t idx, input logic [63:0] val);
        begin
            cfg_valid = 1'b1;
            cfg_index = idx;
            cfg_data  = val;
            do
                @(negedge clk);
            while (!cfg_took);
            cfg_valid = 1'b0;
        end
    endtask

    task automatic set_rule(input logic [63:0] pat, input logic [3:0] plen,
                            input logic [63:0] lo, input logic [63:0] hi,
                            input logic [4:0] rlen);
        begin
            cfg_write(CFG_PATTERN_BYTES, pat);
            cfg_write(CFG_PATTERN_LENGTH, 64'(plen));
            cfg_write(CFG_REPLACE_LOW, lo);
            cfg_write(CFG_REPLACE_HIGH, hi);
            cfg_write(CFG_REPLACE_LENGTH, 64'(rlen));
        end
    endtask

    // Send one text byte; open a random gap between bursts
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(0, gap_max);
                if (gap > 0)
                begin
                    in_valid = 1'b0;
                    repeat (gap) @(negedge clk);
                end
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
            in_valid = 1'b1;
            in_data  = '{in_byte: b, final_byte: fin};
            do
                @(negedge clk);
            while (!in_took);
            bytes_sent++;
        end
    endtask

    // Send up to eight packed bytes, least significant first
    task automatic send_packed(input logic [63:0] bytes, input int n, input bit fin_last);
        begin
            for (int i = 0; i < n; i++)
                send_byte(bytes[i*8 +: 8], fin_last && (i == n - 1));
        end
    endtask

    // Hold the sender until every owed word is back and the block is quiet
    task automatic drain();
        begin
            in_valid = 1'b0;
            while (words_due != 0)
                @(negedge clk);
            repeat (SETTLE) @(negedge clk);
        end
    endtask

    // One rule setting, then a few texts built mostly around the pattern
    task automatic random_phase();
        logic [63:0] pat;
        logic [3:0]  plen_raw;
        logic [4:0]  rlen_raw;
        logic [7:0]  text [$];
        int          width;
        int          texts;
        int          len;
        int          pick;
        int          cut;
        bit          open_end;
        begin
            pat = {$urandom, $urandom};
            if ($urandom_range(0, 7) == 0)
                pat = '1;
            if ($urandom_range(0, 9) == 0)
                plen_raw = 4'($urandom_range(0, 15));
            else
                plen_raw = 4'($urandom_range(1, PATTERN_MAX));
            if ($urandom_range(0, 4) == 0)
                rlen_raw = 5'($urandom_range(0, 31));
            else
                rlen_raw = 5'($urandom_range(0, REPLACE_MAX));
            set_rule(pat, plen_raw, {$urandom, $urandom}, {$urandom, $urandom}, rlen_raw);

            width = (plen_raw == 0) ? 1 : ((plen_raw > PATTERN_MAX) ? PATTERN_MAX : plen_raw);
            case ($urandom_range(0, 2))
                0:       gap_max = 0;
                1:       gap_max = 2;
                default: gap_max = 15;
            endcase

            texts = $urandom_range(1, 3);
            for (int t = 0; t < texts; t++)
            begin
                text.delete();
                len = $urandom_range(1, 24);
                while (text.size() < len)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 35)
                    begin
                        for (int i = 0; i < width; i++)
                            text.push_back(pat[i*8 +: 8]);
                    end
                    else if (pick < 50)
                    begin
                        cut = $urandom_range(1, width);
                        for (int i = 0; i < cut; i++)
                            text.push_back(pat[i*8 +: 8]);
                    end
                    else if (pick < 80)
                        text.push_back(pat[$urandom_range(0, width - 1)*8 +: 8]);
                    else if (pick < 83)
                        text.push_back(8'h00);
                    else
                        text.push_back(8'($urandom_range(1, 255)));
                end
                // Leave the last text open now and then, for the next length write
                open_end = (t == texts - 1) && ($urandom_range(0, 3) == 0);
                for (int i = 0; i < text.size(); i++)
                    send_byte(text[i], !open_end && (i == text.size() - 1));
            end
            drain();
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_PATTERN_BYTES;
        cfg_data   = '0;
        burst_left = 0;
        gap_max    = 3;
        bytes_sent = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset rule: zero pattern of one byte, empty replacement
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        drain();

        // "ab" -> "XYZ" over "xabaabc": miss, hit, miss, hit, tail flush
        set_rule(64'h6261, 4'd2, 64'h5A5958, 64'h0, 5'd3);
        send_packed(64'h63_6261_6162_6178, 7, 1'b1);
        drain();

        // Length write drops a half-filled window
        send_byte(8'h61, 1'b0);
        drain();
        cfg_write(CFG_PATTERN_LENGTH, 64'd2);
        send_byte(8'h62, 1'b1);
        drain();

        // Length zero reads as one; oversized replacement saturates
        set_rule(64'h80, 4'd0, 64'h0011_2233_4455_6677, '1, 5'd31);
        send_byte(8'h80, 1'b1);
        send_byte(8'h7F, 1'b0);
        drain();

        // Oversized pattern length saturates to the full window
        set_rule(64'hFF01_80FF_0102_7EFF, 4'd15, '1, 64'h0, 5'd17);
        send_packed(64'hFF01_80FF_0102_7EFF, 8, 1'b1);
        drain();

        while (bytes_sent < 21 + RANDOM_BYTES)
            random_phase();
        drain();

        if (mismatches == 0 && words_due == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
